[rtl/core/edas_pkg.sv]
// ----------------------------------------------------------------------------
// edas_pkg - shared types and constants of the echo delay autorange scaler
// Register indexes, field widths, reset values and controller/datapath structs.
// ----------------------------------------------------------------------------
package edas_pkg;

  localparam int TIME_BITS_DEF = 16;

  // Configuration register file
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_RANGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_THR  = 1'b1;

  localparam int RANGE_W = 7;
  localparam int THR_W   = 16;
  localparam logic [RANGE_W-1:0] RANGE_RST = 7'd32;
  localparam logic [THR_W-1:0]   THR_RST   = 16'd10;

  // One quotient bit per divide step
  localparam int CNT_W = $clog2(RANGE_W);

  // Controller to datapath
  typedef struct packed {
    logic take;      // input transaction completes this cycle
    logic track;     // update current/min/max
    logic prep;      // spread, validity, clamped offset
    logic mul;       // offset * range, seed divider
    logic div_step;  // one restoring divide step
    logic load_out;  // move result into output register
  } edas_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic armed;
    logic scale_ok;
    logic out_free;
  } edas_status_t;

endpackage

[rtl/core/edas_ctrl.sv]
// ----------------------------------------------------------------------------
// edas_ctrl - sequencing of one echo measurement
// Steps accept, track, prepare, multiply, divide and hand-off.
// ----------------------------------------------------------------------------
module edas_ctrl
  import edas_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_level,
  output logic         in_ready,
  input  edas_status_t status,
  output edas_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRACK,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  div_cnt;
  logic              div_last;

  assign in_ready = (state == ST_IDLE);
  assign div_last = (div_cnt == CNT_W'(RANGE_W - 1));

  always_comb begin
    cmd          = '0;
    cmd.take     = (state == ST_IDLE) && in_valid;
    cmd.track    = (state == ST_TRACK);
    cmd.prep     = (state == ST_PREP);
    cmd.mul      = (state == ST_MUL);
    cmd.div_step = (state == ST_DIV);
    cmd.load_out = (state == ST_DONE) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          // only an echo edge on an armed block yields a result
          if (in_valid && in_level && status.armed) state <= ST_TRACK;
        end
        ST_TRACK: state <= ST_PREP;
        ST_PREP:  state <= ST_MUL;
        ST_MUL: begin
          div_cnt <= '0;
          state   <= status.scale_ok ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_last) state <= ST_DONE;
        end
        ST_DONE: begin
          if (status.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/edas_dp.sv]
// ----------------------------------------------------------------------------
// edas_dp - datapath of the echo delay autorange scaler
// Stamp/tracking registers, config registers, multiplier, serial divider and
// output register.
// ----------------------------------------------------------------------------
module edas_dp
  import edas_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [TIME_BITS-1:0]  capture_time,
  input  logic                  edge_level,
  input  edas_cmd_t             cmd,
  output edas_status_t          status,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [TIME_BITS-1:0]  echo_delay,
  output logic [RANGE_W-1:0]    scaled_delay,
  output logic                  scale_valid
);

  localparam int P_W   = TIME_BITS + RANGE_W;
  localparam int CMP_W = (TIME_BITS > THR_W) ? TIME_BITS : THR_W;

  logic [RANGE_W-1:0]   scale_range;
  logic [THR_W-1:0]     spread_thr;

  logic [TIME_BITS-1:0] start_stamp;
  logic                 armed;
  logic [TIME_BITS-1:0] delay;
  logic [TIME_BITS-1:0] cur_delay;
  logic [TIME_BITS-1:0] min_delay;
  logic [TIME_BITS-1:0] max_delay;

  logic [TIME_BITS-1:0] spread;
  logic [TIME_BITS-1:0] offset;
  logic                 scale_ok;

  logic [TIME_BITS-1:0] rem;
  logic [RANGE_W-1:0]   low;
  logic [RANGE_W-1:0]   quot;

  logic [TIME_BITS-1:0] spread_c;
  logic                 ok_c;
  logic [TIME_BITS-1:0] offset_c;
  logic [P_W-1:0]       prod_c;
  logic [TIME_BITS:0]   trial;
  logic [TIME_BITS:0]   diff;
  logic                 ge;

  assign status.armed    = armed;
  assign status.scale_ok = scale_ok;
  assign status.out_free = !out_valid || out_ready;

  always_comb begin
    spread_c = max_delay - min_delay;
    ok_c     = (max_delay > min_delay) && (CMP_W'(spread_c) > CMP_W'(spread_thr));
    if (cur_delay <= min_delay)      offset_c = '0;
    else if (cur_delay >= max_delay) offset_c = spread_c;
    else                             offset_c = cur_delay - min_delay;
  end

  // quotient < 2^RANGE_W, so the upper product bits already sit below spread
  assign prod_c = P_W'(offset) * P_W'(scale_range);
  assign trial  = {rem, low[RANGE_W-1]};
  assign diff   = trial - {1'b0, spread};
  assign ge     = (trial >= {1'b0, spread});

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_range <= RANGE_RST;
      spread_thr  <= THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE_RANGE: scale_range <= cfg_data[RANGE_W-1:0];
        CFG_SPREAD_THR:  spread_thr  <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= 1'b0;
      cur_delay <= '0;
      min_delay <= '1;
      max_delay <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.take) begin
        if (!edge_level) begin
          start_stamp <= capture_time;
          armed       <= 1'b1;
        end else if (armed) begin
          delay <= capture_time - start_stamp;
          armed <= 1'b0;
        end
      end
      if (cmd.track && (delay != cur_delay)) begin
        cur_delay <= delay;
        if (min_delay > delay) min_delay <= delay;
        if (max_delay < delay) max_delay <= delay;
      end
      if (cmd.load_out)     out_valid <= 1'b1;
      else if (out_ready)   out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      spread   <= spread_c;
      scale_ok <= ok_c;
      offset   <= offset_c;
    end
    if (cmd.mul) begin
      rem  <= prod_c[P_W-1:RANGE_W];
      low  <= prod_c[RANGE_W-1:0];
      quot <= '0;
    end
    if (cmd.div_step) begin
      rem  <= ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
      low  <= {low[RANGE_W-2:0], 1'b0};
      quot <= {quot[RANGE_W-2:0], ge};
    end
    if (cmd.load_out) begin
      echo_delay   <= delay;
      scaled_delay <= scale_ok ? quot : '0;
      scale_valid  <= scale_ok;
    end
  end

endmodule

[rtl/core/echo_delay_autorange_scaler_top.sv]
// ----------------------------------------------------------------------------
// echo_delay_autorange_scaler_top - echo delay measurement with auto-ranging
// Top level: stream ports, config port, controller and datapath.
// ----------------------------------------------------------------------------
// Each input transaction is a comparator edge: s_tdata holds the capture time,
// s_tuser the level after the edge. A falling edge (level 0) stores the stamp
// and arms the block; the block stays idle and gives no result. A rising edge on
// an armed block measures delay = stamp - start modulo 2^TIME_BITS, disarms,
// folds a changed delay into the tracked current/min/max, and produces one
// result: the delay and the current delay scaled as
// (cur-min)*scale_range/(max-min), rounded down. scale_valid (m_tuser) is set
// only when max > min and max-min exceeds spread_threshold; otherwise the
// scaled field is 0 and no divide is run. A rising edge on a disarmed block is
// dropped. A measuring edge occupies the block through accept, track,
// prepare, multiply, RANGE_W = 7 restoring divide steps on a shared
// subtractor and hand-off, the divide skipped when the scale is invalid;
// s_tready stays low meanwhile. The result sits in an output register, so
// the block takes the next edge while a result still waits on m_tready; it
// only stalls at hand-off if the previous result has not yet been taken.
// Config writes (cfg_index 0: scale_range, 1: spread_threshold) take effect
// at the next edge and are meant to happen only while the block is idle.
module echo_delay_autorange_scaler_top
  import edas_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF,
  localparam int S_DATA_W = ((TIME_BITS + 7) / 8) * 8,
  localparam int M_DATA_W = ((TIME_BITS + RANGE_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // edge events
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,   // capture_time, zero pad
  input  logic                  s_tuser,   // edge_level
  // results
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_DATA_W-1:0]   m_tdata,   // echo_delay, scaled_delay, zero pad
  output logic                  m_tuser    // scale_valid
);

  edas_cmd_t            cmd;
  edas_status_t         status;
  logic [TIME_BITS-1:0] echo_delay;
  logic [RANGE_W-1:0]   scaled_delay;

  edas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_level (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  edas_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .capture_time (s_tdata[TIME_BITS-1:0]),
    .edge_level   (s_tuser),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .echo_delay   (echo_delay),
    .scaled_delay (scaled_delay),
    .scale_valid  (m_tuser)
  );

  // pack result fields, lowest first
  always_comb begin
    m_tdata                         = '0;
    m_tdata[TIME_BITS-1:0]          = echo_delay;
    m_tdata[TIME_BITS +: RANGE_W]   = scaled_delay;
  end

endmodule

[rtl/core/edas_checker.sv]
// ----------------------------------------------------------------------------
// edas_checker - port-level checks on the echo delay autorange scaler
// Bound to the top level; watches handshakes and result fields over time.
// ----------------------------------------------------------------------------
module edas_checker
  import edas_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int M_DATA_W  = ((TIME_BITS + RANGE_W + 7) / 8) * 8
) (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                s_tuser,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic                m_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // an invalid scale always reads zero
  a_scaled_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[TIME_BITS +: RANGE_W] == '0))
    else $error("scaled delay non-zero with scale invalid");

  // a start edge never yields a result
  a_start_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> !$rose(m_tvalid))
    else $error("result after start edge");

  // a new result is only issued from the busy phase of a measurement
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result issued while input side idle");

endmodule

bind echo_delay_autorange_scaler_top edas_checker #(
  .TIME_BITS (TIME_BITS),
  .M_DATA_W  (M_DATA_W)
) u_edas_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[tb/echo_result_checker.sv]
// ----------------------------------------------------------------------------
// echo_result_checker - result predictor and comparator for the echo scaler
// Follows the edge, result and config channels, keeps its own copy of the
// tracked delays and registers, and checks each result transaction in order.
// ----------------------------------------------------------------------------
module echo_result_checker
  import edas_pkg::*;
#(
  parameter int S_W = 16,
  parameter int M_W = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [S_W-1:0]        s_tdata,   // capture_time, zero pad
  input  logic                  s_tuser,   // edge_level
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_W-1:0]        m_tdata,   // echo_delay, scaled_delay, zero pad
  input  logic                  m_tuser,   // scale_valid
  output int                    mismatches,
  output int                    outstanding
);

  localparam int TW = TIME_BITS_DEF;

  typedef logic [TW-1:0] tick_t;

  typedef struct packed {
    tick_t              delay;
    logic [RANGE_W-1:0] scaled;
    logic               valid;
  } echo_result_t;

  logic [RANGE_W-1:0] range_q;
  logic [THR_W-1:0]   thr_q;
  tick_t              start_q;
  tick_t              cur_q;
  tick_t              min_q;
  tick_t              max_q;
  logic               armed_q;
  echo_result_t       results_due[$];
  int                 n_bad = 0;
  int                 n_due = 0;

  assign mismatches  = n_bad;
  assign outstanding = n_due;

  // Scaled position of the current delay between tracked min and max
  function automatic echo_result_t scale_delay(tick_t delay);
    echo_result_t               r;
    tick_t                      spread;
    tick_t                      offset;
    logic [TW+RANGE_W-1:0]      prod;
    r.delay  = delay;
    r.scaled = '0;
    r.valid  = 1'b0;
    if (max_q > min_q) begin
      spread = max_q - min_q;
      if (spread > thr_q) begin
        if (cur_q <= min_q) offset = '0;
        else if (cur_q >= max_q) offset = spread;
        else offset = cur_q - min_q;
        prod     = {{RANGE_W{1'b0}}, offset} * {{TW{1'b0}}, range_q};
        r.scaled = RANGE_W'(prod / {{RANGE_W{1'b0}}, spread});
        r.valid  = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    echo_result_t got;
    echo_result_t want;
    tick_t        stamp;
    tick_t        delay;
    if (rst) begin
      range_q = RANGE_RST;
      thr_q   = THR_RST;
      start_q = '0;
      armed_q = 1'b0;
      cur_q   = '0;
      min_q   = '1;
      max_q   = '0;
      results_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SCALE_RANGE) range_q = cfg_data[RANGE_W-1:0];
        else if (cfg_index == CFG_SPREAD_THR) thr_q = cfg_data[THR_W-1:0];
      end
      // result side first: nothing leaves in the cycle its edge arrives
      if (m_tvalid && m_tready) begin
        got.delay  = m_tdata[TW-1:0];
        got.scaled = m_tdata[TW +: RANGE_W];
        got.valid  = m_tuser;
        if (results_due.size() == 0) begin
          $error("unexpected result: echo_delay %0d scaled_delay %0d scale_valid %0b",
                 got.delay, got.scaled, got.valid);
          n_bad++;
        end else begin
          want = results_due.pop_front();
          if (got.delay !== want.delay) begin
            $error("echo_delay: expected %0d, got %0d", want.delay, got.delay);
            n_bad++;
          end
          if (got.scaled !== want.scaled) begin
            $error("scaled_delay: expected %0d, got %0d", want.scaled, got.scaled);
            n_bad++;
          end
          if (got.valid !== want.valid) begin
            $error("scale_valid: expected %0b, got %0b", want.valid, got.valid);
            n_bad++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        stamp = s_tdata[TW-1:0];
        if (!s_tuser) begin
          start_q = stamp;
          armed_q = 1'b1;
        end else if (armed_q) begin
          armed_q = 1'b0;
          delay   = stamp - start_q;
          if (delay != cur_q) begin
            cur_q = delay;
            if (min_q > delay) min_q = delay;
            if (max_q < delay) max_q = delay;
          end
          results_due.push_back(scale_delay(delay));
        end
      end
    end
    n_due = results_due.size();
  end

endmodule

[tb/echo_delay_autorange_scaler_top_tb.sv]
// ----------------------------------------------------------------------------
// echo_delay_autorange_scaler_top_tb - regression bench for the echo scaler
// Drives comparator edge transactions and register writes, stalls both stream
// sides at random, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module echo_delay_autorange_scaler_top_tb;
  import edas_pkg::*;

  localparam int TW       = TIME_BITS_DEF;
  localparam int S_W      = ((TW + 7) / 8) * 8;
  localparam int M_W      = ((TW + RANGE_W + 7) / 8) * 8;
  localparam int N_EDGES  = 1450;     // rough size of the random part
  localparam int N_PHASES = 8;
  localparam int CENTRE   = 20000;    // typical echo delay in ticks

  typedef logic [TW-1:0] tick_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_W-1:0]        s_tdata   = '0;   // capture_time, zero pad
  logic                  s_tuser   = 1'b0; // edge_level
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_W-1:0]        m_tdata;          // echo_delay, scaled_delay, zero pad
  logic                  m_tuser;          // scale_valid

  int   mismatches;
  int   outstanding;

  // idling switches, cleared for the quiet stretch
  logic tx_gaps   = 1'b1;
  logic rx_stalls = 1'b1;

  // sender's view of the arming, only used to count edges that do work
  logic  armed_drv  = 1'b0;
  int    n_edges    = 0;
  tick_t last_delay = '0;

  echo_delay_autorange_scaler_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  echo_result_checker #(
    .S_W(S_W),
    .M_W(M_W)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result sink: back-pressure in about a quarter of the cycles
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rx_stalls || ($urandom_range(99) >= 25);
    end
  end

  // Random gap before a transaction. Valid is only dropped here, so a valid
  // that carries straight on to the next edge never toggles within a step.
  task automatic tx_gap();
    while (tx_gaps && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // One edge transaction; returns once it has been taken
  task automatic put_edge(input tick_t stamp, input logic level);
    tx_gap();
    s_tvalid <= 1'b1;
    s_tdata  <= S_W'(stamp);
    s_tuser  <= level;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // a rising edge on a disarmed block is dropped and does not count
    if (!level || armed_drv) n_edges++;
    armed_drv = !level;
  endtask

  // Start edge then echo edge, 'delay' ticks apart (wraps in 16 bits)
  task automatic ping(input tick_t start, input tick_t delay);
    put_edge(start, 1'b0);
    put_edge(start + delay, 1'b1);
    last_delay = delay;
  endtask

  // Drain all pending results, then allow for a falling edge still in
  // flight (no result to wait for) before the registers are touched.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (16) @(posedge clk);
  endtask

  // Write both registers on consecutive cycles while the block is idle
  task automatic set_scale(input int unsigned range, input int unsigned thr);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SCALE_RANGE;
    cfg_data  <= CFG_DATA_W'(range);
    @(posedge clk);
    cfg_index <= CFG_SPREAD_THR;
    cfg_data  <= CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned range;
    int unsigned thr;
    int unsigned half;
    tick_t       delay;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part, reset register values (range 32, threshold 10) ----
    put_edge(16'h0000, 1'b1);          // echo with nothing armed: dropped
    put_edge(16'hFFFF, 1'b0);
    put_edge(16'hFFFF, 1'b1);          // zero delay equals reset current: no update
    ping(16'hFFF0, 16'd20000);         // stamp wraps past all ones; spread still zero
    put_edge(16'd100, 1'b0);
    ping(16'd200, 16'd20040);          // re-armed start replaces the first stamp
    ping(16'h5A5A, 16'd20020);         // mid-scale
    ping(16'hA5A5, 16'd20020);         // same delay again: tracking unchanged
    ping(16'h1234, 16'd19990);         // new minimum, bottom of scale
    put_edge(16'h7FFF, 1'b1);          // dropped again
    set_scale(64, 50);
    ping(16'h0F0F, 16'd20040);         // spread equal to threshold: not valid
    set_scale(64, 49);
    ping(16'hF0F0, 16'd20000);         // just over threshold

    // ---- random part: phases with their own register settings and a delay
    // window that widens, so the spread crosses the thresholds over time ----
    n_edges = 0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin range = 32; thr = 10;    half = 16;    end
        1: begin range = 1;  thr = 0;     half = 64;    end
        2: begin range = 64; thr = 65535; half = 256;   end
        3: begin range = 0;  thr = 0;     half = 1024;  end  // degenerate scale
        4: begin range = $urandom_range(1, 64); thr = $urandom_range(2000);  half = 4096;  end
        5: begin range = 64; thr = 100;   half = 8192;  end
        6: begin range = $urandom_range(1, 64); thr = $urandom_range(65535); half = 20000; end
        default: begin range = 64; thr = 0; half = 32768; end
      endcase
      set_scale(range, thr);
      // one long quiet stretch with no gaps and no back-pressure
      tx_gaps   = (ph != 3);
      rx_stalls = (ph != 3);
      if (ph == N_PHASES - 1) begin
        ping(tick_t'($urandom), 16'd0);       // smallest possible delay
        ping(tick_t'($urandom), 16'hFFFF);    // largest possible delay
      end
      while (n_edges < (ph + 1) * N_EDGES / N_PHASES) begin
        if ($urandom_range(99) < 15) begin
          // noise: lone starts, unarmed echoes, random stamps
          put_edge(tick_t'($urandom), 1'($urandom_range(1)));
        end else begin
          if ($urandom_range(99) < 10) delay = last_delay;
          else if (ph == N_PHASES - 1) delay = tick_t'($urandom_range(65535));
          else delay = tick_t'(CENTRE - half + $urandom_range(2 * half));
          ping(tick_t'($urandom), delay);
        end
      end
    end

    // ---- wind down: everything taken, give the block time to misbehave ----
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #6000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
